// ===== hdl/wpp_pkg.sv =====
// Shared types and constants of the RIFF/WAVE PCM byte-stream parser.
// Holds the result beat layout, result kinds and error codes.
// No dependencies.
package wpp_pkg;

	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;
	localparam logic [32:0] POS_MAX  = 33'h1_FFFF_FFFF;
	localparam logic [31:0] FMT_SIZE = 32'd16;

	localparam logic [1:0] KIND_FORMAT = 2'd0;
	localparam logic [1:0] KIND_SAMPLE = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;
	localparam logic [1:0] KIND_EMPTY  = 2'd3;

	localparam logic [2:0] ERR_NO_RIFF   = 3'd0;
	localparam logic [2:0] ERR_NO_WAVE   = 3'd1;
	localparam logic [2:0] ERR_NO_FMT    = 3'd2;
	localparam logic [2:0] ERR_NOT_PCM   = 3'd3;
	localparam logic [2:0] ERR_NO_DATA   = 3'd4;
	localparam logic [2:0] ERR_BAD_WIDTH = 3'd5;
	localparam logic [2:0] ERR_TRUNCATED = 3'd6;

	// One input beat: file byte plus end-of-file mark.
	typedef struct packed {
		logic       end_of_file;
		logic [7:0] data_byte;
	} wpp_byte_t;

	// One result beat.
	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] sample_value;
		logic [15:0] channel;
		logic [31:0] frame_index;
		logic [15:0] channel_count;
		logic [31:0] rate_hz;
		logic [15:0] sample_width;
		logic [2:0]  error_code;
		logic        last;
	} wpp_res_t;

endpackage

// ===== hdl/wav_pcm_stream_parser.sv =====
// RIFF/WAVE PCM parser taking one file byte a beat and giving format, sample
// and error beats. The parser core takes one byte a cycle while the result queue
// has room and no division runs. After the last byte of the data chunk's size
// header, the frame count goes through a one-bit-a-cycle divider, and bytes wait
// in the input queue meanwhile. Results pass through a queue of their own, so
// bytes keep flowing while a result waits to be popped.
// Depends on wpp_pkg, wpp_fifo and wpp_core.
module wav_pcm_stream_parser #(
	parameter int IN_DEPTH_LOG2 = 2,
	parameter int OUT_DEPTH_LOG2 = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        end_of_file,
	input  logic        pop,
	output logic        empty,
	output logic [1:0]  kind,
	output logic [31:0] sample_value,
	output logic [15:0] channel,
	output logic [31:0] frame_index,
	output logic [15:0] channel_count,
	output logic [31:0] rate_hz,
	output logic [15:0] sample_width,
	output logic [2:0]  error_code,
	output logic        last
);
	import wpp_pkg::*;

	wpp_byte_t in_w, in_r;
	wpp_res_t  res_w, res_r;
	logic      in_empty, in_take, out_full, out_push;

	assign in_w.data_byte   = data_byte;
	assign in_w.end_of_file = end_of_file;

	// front: byte queue
	wpp_fifo #(.W($bits(wpp_byte_t)), .DEPTH_LOG2(IN_DEPTH_LOG2)) u_in (
		.clk(clk), .arst_n(arst_n), .wr(push), .wdata(in_w), .full(full),
		.rd(in_take), .empty(in_empty), .rdata(in_r)
	);

	wpp_core u_core (
		.clk(clk), .arst_n(arst_n), .in_valid(!in_empty), .in_beat(in_r),
		.in_take(in_take), .out_full(out_full), .out_push(out_push), .out_beat(res_w)
	);

	// back: result queue
	wpp_fifo #(.W($bits(wpp_res_t)), .DEPTH_LOG2(OUT_DEPTH_LOG2)) u_out (
		.clk(clk), .arst_n(arst_n), .wr(out_push), .wdata(res_w), .full(out_full),
		.rd(pop), .empty(empty), .rdata(res_r)
	);

	assign kind          = res_r.kind;
	assign sample_value  = res_r.sample_value;
	assign channel       = res_r.channel;
	assign frame_index   = res_r.frame_index;
	assign channel_count = res_r.channel_count;
	assign rate_hz       = res_r.rate_hz;
	assign sample_width  = res_r.sample_width;
	assign error_code    = res_r.error_code;
	assign last          = res_r.last;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> !out_full) else $error("result pushed into a full queue");
	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |-> !in_empty) else $error("byte taken from an empty queue");
	a_push_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(out_push && res_w.kind == KIND_SAMPLE) |-> (res_w.error_code == ERR_NO_RIFF))
		else $error("sample beat carries an error code");

endmodule

// ===== hdl/wpp_fifo.sv =====
// Small synchronous queue built from a register array.
// Used for the input byte queue and the result queue; no package needed.
module wpp_fifo #(
	parameter int W = 8,
	parameter int DEPTH_LOG2 = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         rd,
	output logic         empty,
	output logic [W-1:0] rdata
);
	localparam int DEPTH = 1 << DEPTH_LOG2;

	logic [W-1:0]          mem_q [DEPTH];
	logic [DEPTH_LOG2-1:0] wptr_q, rptr_q;
	logic [DEPTH_LOG2:0]   cnt_q;
	logic                  do_wr, do_rd;

	assign full  = (cnt_q == DEPTH_LOG2'(0) + (DEPTH_LOG2+1)'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rptr_q];

	// store beat
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/wpp_div.sv =====
// Radix-2 restoring divider, 32-bit dividend by 16-bit divisor, one bit a cycle.
// Standalone; used by the parser core for the frame count of the data chunk.
module wpp_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [15:0] divisor,
	output logic        busy,
	output logic [31:0] quotient
);
	logic [16:0] rem_q;
	logic [31:0] quo_q;
	logic [15:0] dvs_q;
	logic [5:0]  cnt_q;
	logic [16:0] trial;
	logic        fits;

	assign busy     = (cnt_q != '0);
	assign quotient = quo_q;
	assign trial    = {rem_q[15:0], quo_q[31]};
	assign fits     = (trial >= {1'b0, dvs_q});

	// shift in one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy) begin
			rem_q <= fits ? (trial - {1'b0, dvs_q}) : trial;
			quo_q <= {quo_q[30:0], fits};
		end
	end

	// count steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 6'd32;
		end else if (busy) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

endmodule

// ===== hdl/wpp_core.sv =====
// Parser engine: walks the RIFF header, chunk search, fmt fields and sample data.
// Depends on wpp_pkg and wpp_div.
module wpp_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  wpp_pkg::wpp_byte_t in_beat,
	output logic              in_take,
	input  logic              out_full,
	output logic              out_push,
	output wpp_pkg::wpp_res_t out_beat
);
	import wpp_pkg::*;

	typedef enum logic [4:0] {
		P_RIFF, P_RLEN, P_WAVE,
		P_SEEK_FMT, P_SKIPLEN_FMT, P_SKIP_FMT,
		P_FSIZE, P_FFMT, P_CHANS, P_RATE, P_BRATE, P_ALIGN, P_BITS,
		P_SEEK_DATA, P_SKIPLEN_DATA, P_SKIP_DATA,
		P_DSIZE, P_DIVW, P_SAMPLES, P_IDLE
	} phase_t;

	phase_t      phase_q, phase_n;
	logic [32:0] pos_q, pos_n, rend_q, rend_n, skip_q, skip_n;
	logic [31:0] fsh_q, fsh_n, rate_q, rate_n, drem_q, drem_n, fcnt_q, fcnt_n;
	logic [31:0] ssh_q, ssh_n;
	logic [2:0]  fbc_q, fbc_n;
	logic [15:0] chans_q, chans_n, align_q, align_n, width_q, width_n;
	logic [15:0] chi_q, chi_n, bif_q, bif_n;
	logic [17:0] fbytes_q, fbytes_n;
	logic        eofp_q, eofp_n;

	logic        fire, finish, div_busy, div_start, eof, wok, fmt_ok, seek_fail;
	logic [31:0] div_quo, gsh, ssh, frames, flip;
	logic [7:0]  b;
	logic [2:0]  gcnt, glen, bps, sbps;
	logic [17:0] fb;
	logic [33:0] rend_chk;
	logic [15:0] v16;
	wpp_res_t    res;
	logic        emit;

	assign b        = in_beat.data_byte;
	assign eof      = in_beat.end_of_file;
	assign fire     = in_valid && !out_full && (phase_q != P_DIVW);
	assign finish   = (phase_q == P_DIVW) && !div_busy && !out_full;
	assign in_take  = fire;
	assign out_push = emit;
	assign out_beat = res;

	assign gsh  = fsh_q | ({24'd0, b} << {fbc_q[1:0], 3'd0});
	assign gcnt = fbc_q + 3'd1;
	assign v16  = gsh[15:0];
	assign sbps = width_q[5:3];
	assign ssh  = ssh_q | ({24'd0, b} << {fbc_q[1:0], 3'd0});
	assign flip = (width_q > 16'd8) ? (32'd1 << (width_q[4:0] - 5'd1)) : 32'd0;
	assign frames = (align_q == '0) ? '0 : div_quo;

	// field lengths of the gathering phases
	always_comb begin
		case (phase_q)
			P_FFMT, P_CHANS, P_ALIGN, P_BITS: glen = 3'd2;
			default: glen = 3'd4;
		endcase
	end

	// width check and bytes of sample data in one frame
	always_comb begin
		wok = (v16 == 16'd8) || (v16 == 16'd16) || (v16 == 16'd24) || (v16 == 16'd32);
		bps = v16[5:3];
		case (bps)
			3'd1:    fb = {2'b0, chans_q};
			3'd2:    fb = {1'b0, chans_q, 1'b0};
			3'd3:    fb = {2'b0, chans_q} + {1'b0, chans_q, 1'b0};
			3'd4:    fb = {chans_q, 2'b0};
			default: fb = '0;
		endcase
		fmt_ok = wok && (chans_q != '0) && (align_q != '0) && ({2'b0, align_q} >= fb);
	end

	// next state for one byte or for the end of the division
	always_comb begin
		phase_n = phase_q; pos_n = pos_q; rend_n = rend_q; skip_n = skip_q;
		fsh_n = fsh_q; fbc_n = fbc_q; rate_n = rate_q; drem_n = drem_q;
		fcnt_n = fcnt_q; ssh_n = ssh_q; chans_n = chans_q; align_n = align_q;
		width_n = width_q; chi_n = chi_q; bif_n = bif_q; fbytes_n = fbytes_q;
		eofp_n = eofp_q;
		res = '0; emit = 1'b0; div_start = 1'b0;
		rend_chk = '0; seek_fail = 1'b0;
		if (fire) begin
			pos_n = (pos_q == POS_MAX) ? pos_q : pos_q + 33'd1;
			// gather little-endian field bytes
			if (phase_q != P_SKIP_FMT && phase_q != P_SKIP_DATA &&
			    phase_q != P_SAMPLES && phase_q != P_IDLE) begin
				if (gcnt >= glen) begin
					fsh_n = '0;
					fbc_n = '0;
				end else begin
					fsh_n = gsh;
					fbc_n = gcnt;
				end
			end
			case (phase_q)
				P_RIFF: begin
					if (gcnt >= glen) begin
						if (gsh == TAG_RIFF) begin
							phase_n = P_RLEN;
						end else begin
							emit = 1'b1; res.kind = KIND_ERROR;
							res.error_code = ERR_NO_RIFF; phase_n = P_IDLE;
						end
					end
				end
				P_RLEN: begin
					if (gcnt >= glen) begin
						rend_n = {1'b0, gsh} + pos_n;
						phase_n = P_WAVE;
					end
				end
				P_WAVE: begin
					if (gcnt >= glen) begin
						if (gsh == TAG_WAVE) begin
							phase_n = P_SEEK_FMT;
						end else begin
							emit = 1'b1; res.kind = KIND_ERROR;
							res.error_code = ERR_NO_WAVE; phase_n = P_IDLE;
						end
					end
				end
				P_SEEK_FMT, P_SEEK_DATA: begin
					if (fbc_q == '0 && !(({1'b0, pos_q} + 34'd4) < {1'b0, rend_q})) begin
						emit = 1'b1; res.kind = KIND_ERROR;
						res.error_code = (phase_q == P_SEEK_DATA) ? ERR_NO_DATA : ERR_NO_FMT;
						phase_n = P_IDLE;
						fsh_n = '0; fbc_n = '0;
					end else if (gcnt >= glen) begin
						if (phase_q == P_SEEK_DATA) begin
							phase_n = (gsh == TAG_DATA) ? P_DSIZE : P_SKIPLEN_DATA;
						end else begin
							phase_n = (gsh == TAG_FMT) ? P_FSIZE : P_SKIPLEN_FMT;
						end
					end
				end
				P_SKIPLEN_FMT, P_SKIPLEN_DATA: begin
					if (gcnt >= glen) begin
						skip_n = {1'b0, gsh} + {32'd0, gsh[0]};
						if (skip_n != '0) begin
							phase_n = (phase_q == P_SKIPLEN_DATA) ? P_SKIP_DATA : P_SKIP_FMT;
						end else begin
							phase_n = (phase_q == P_SKIPLEN_DATA) ? P_SEEK_DATA : P_SEEK_FMT;
						end
					end
				end
				P_SKIP_FMT, P_SKIP_DATA: begin
					skip_n = (skip_q != '0) ? skip_q - 33'd1 : skip_q;
					if (skip_n == '0) begin
						phase_n = (phase_q == P_SKIP_DATA) ? P_SEEK_DATA : P_SEEK_FMT;
					end
				end
				P_FSIZE: begin
					if (gcnt >= glen) begin
						skip_n = {1'b0, gsh};
						phase_n = P_FFMT;
					end
				end
				P_FFMT: begin
					if (gcnt >= glen) begin
						if (gsh != 32'd1 || skip_q != {1'b0, FMT_SIZE}) begin
							emit = 1'b1; res.kind = KIND_ERROR;
							res.error_code = ERR_NOT_PCM; phase_n = P_IDLE;
						end else begin
							skip_n = '0;
							phase_n = P_CHANS;
						end
					end
				end
				P_CHANS: begin
					if (gcnt >= glen) begin
						chans_n = v16; phase_n = P_RATE;
					end
				end
				P_RATE: begin
					if (gcnt >= glen) begin
						rate_n = gsh; phase_n = P_BRATE;
					end
				end
				P_BRATE: begin
					if (gcnt >= glen) begin
						phase_n = P_ALIGN;
					end
				end
				P_ALIGN: begin
					if (gcnt >= glen) begin
						align_n = v16; phase_n = P_BITS;
					end
				end
				P_BITS: begin
					if (gcnt >= glen) begin
						width_n = v16;
						fbytes_n = fb;
						emit = 1'b1;
						if (!fmt_ok) begin
							res.kind = KIND_ERROR; res.error_code = ERR_BAD_WIDTH;
							phase_n = P_IDLE;
						end else begin
							res.kind = KIND_FORMAT; res.channel_count = chans_q;
							res.rate_hz = rate_q; res.sample_width = v16;
							phase_n = P_SEEK_DATA;
						end
					end
				end
				P_DSIZE: begin
					if (gcnt >= glen) begin
						div_start = 1'b1;
						eofp_n = eof;
						phase_n = P_DIVW;
					end
				end
				P_SAMPLES: begin
					if ({2'b0, bif_q} < fbytes_q) begin
						ssh_n = ssh;
						fbc_n = gcnt;
						if (gcnt >= sbps) begin
							emit = 1'b1; res.kind = KIND_SAMPLE;
							res.sample_value = ssh ^ flip; res.channel = chi_q;
							res.frame_index = fcnt_q;
							res.last = ({1'b0, chi_q} + 17'd1 == {1'b0, chans_q}) &&
							           (drem_q == 32'd1);
							chi_n = chi_q + 16'd1;
							fbc_n = '0; ssh_n = '0;
						end
					end
					bif_n = bif_q + 16'd1;
					if (bif_n >= align_q) begin
						bif_n = '0; chi_n = '0; fbc_n = '0; ssh_n = '0;
						fcnt_n = fcnt_q + 32'd1;
						drem_n = drem_q - 32'd1;
						if (drem_n == '0) begin
							phase_n = P_IDLE;
						end
					end
				end
				default: begin
					phase_n = P_IDLE;
				end
			endcase
		end else if (finish) begin
			// apply the frame count of the data chunk
			if (frames == '0) begin
				emit = 1'b1; res.kind = KIND_EMPTY; phase_n = P_IDLE;
			end else begin
				drem_n = frames; fcnt_n = '0; chi_n = '0; bif_n = '0; ssh_n = '0;
				phase_n = P_SAMPLES;
			end
		end

		// end of file: flag an unfinished parse, then restart
		if ((fire && eof && !(phase_q == P_DSIZE && gcnt >= glen)) ||
		    (finish && eofp_q)) begin
			if (phase_n != P_IDLE && !(emit && res.kind == KIND_ERROR)) begin
				rend_chk = {1'b0, pos_n} + 34'd4;
				seek_fail = (phase_n == P_SEEK_FMT || phase_n == P_SEEK_DATA) &&
				            (fbc_n == '0) && !(rend_chk < {1'b0, rend_n});
				res = '0; emit = 1'b1; res.kind = KIND_ERROR;
				res.error_code = !seek_fail ? ERR_TRUNCATED :
				                 (phase_n == P_SEEK_DATA) ? ERR_NO_DATA : ERR_NO_FMT;
			end
			phase_n = P_RIFF; pos_n = '0; rend_n = '0; skip_n = '0; fsh_n = '0;
			fbc_n = '0; rate_n = '0; drem_n = '0; fcnt_n = '0; ssh_n = '0;
			chans_n = '0; align_n = '0; width_n = '0; chi_n = '0; bif_n = '0;
			fbytes_n = '0; eofp_n = 1'b0;
		end
	end

	// hold parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_RIFF; pos_q <= '0; rend_q <= '0; skip_q <= '0;
			fsh_q <= '0; fbc_q <= '0; rate_q <= '0; drem_q <= '0; fcnt_q <= '0;
			ssh_q <= '0; chans_q <= '0; align_q <= '0; width_q <= '0;
			chi_q <= '0; bif_q <= '0; fbytes_q <= '0; eofp_q <= 1'b0;
		end else begin
			phase_q <= phase_n; pos_q <= pos_n; rend_q <= rend_n; skip_q <= skip_n;
			fsh_q <= fsh_n; fbc_q <= fbc_n; rate_q <= rate_n; drem_q <= drem_n;
			fcnt_q <= fcnt_n; ssh_q <= ssh_n; chans_q <= chans_n; align_q <= align_n;
			width_q <= width_n; chi_q <= chi_n; bif_q <= bif_n; fbytes_q <= fbytes_n;
			eofp_q <= eofp_n;
		end
	end

	wpp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (gsh),
		.divisor  (align_q),
		.busy     (div_busy),
		.quotient (div_quo)
	);

endmodule
